[design/mtfw_pkg.sv]
// ----------------------------------------------------------------------------
// mtfw_pkg
// Shared types and codes for the mutex table with FIFO waiter queues.
// ----------------------------------------------------------------------------
package mtfw_pkg;

    localparam int LOCK_SLOTS   = 16;
    localparam int THREAD_COUNT = 16;
    localparam int SLOT_W       = $clog2(LOCK_SLOTS);
    localparam int THREAD_W     = $clog2(THREAD_COUNT);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    typedef logic [SLOT_W-1:0]   t_slot;
    typedef logic [THREAD_W-1:0] t_thread;

    // request opcodes as they arrive on the input channel
    typedef enum logic [2:0] {
        OP_INIT    = 3'd0,
        OP_DESTROY = 3'd1,
        OP_LOCK    = 3'd2,
        OP_TRYLOCK = 3'd3,
        OP_UNLOCK  = 3'd4
    } t_op_code;

    // classified command carried to the back end
    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_INIT,
        CMD_DESTROY,
        CMD_LOCK,
        CMD_TRYLOCK,
        CMD_UNLOCK
    } t_cmd_kind;

    typedef enum logic [3:0] {
        OC_ACQUIRED     = 4'd0,
        OC_QUEUED       = 4'd1,
        OC_BUSY         = 4'd2,
        OC_RELEASED     = 4'd3,
        OC_HANDOFF      = 4'd4,
        OC_ALREADY_FREE = 4'd5,
        OC_REFUSED      = 4'd6,
        OC_ABSENT       = 4'd7,
        OC_DONE         = 4'd8
    } t_outcome;

    typedef struct packed {
        logic [2:0] op;
        logic [3:0] lock_id;
        logic [3:0] thread_id;
    } t_req;

    typedef struct packed {
        t_outcome   outcome;
        logic       implicit_created;
        logic       woken_valid;
        logic [3:0] woken_thread;
    } t_rsp;

    typedef struct packed {
        t_cmd_kind kind;
        t_slot     slot;
        t_thread   thread;
    } t_cmd;

endpackage

[design/mtfw_front.sv]
// ----------------------------------------------------------------------------
// mtfw_front
// Request classifier: decodes the opcode and reduces the slot and thread
// indices to the table sizes.
// ----------------------------------------------------------------------------
module mtfw_front (
    input  mtfw_pkg::t_req i_req,
    output mtfw_pkg::t_cmd o_cmd
);
    import mtfw_pkg::*;

    always_comb begin
        o_cmd.slot   = t_slot'(i_req.lock_id);
        o_cmd.thread = t_thread'(i_req.thread_id);
        unique case (i_req.op)
            OP_INIT:    o_cmd.kind = CMD_INIT;
            OP_DESTROY: o_cmd.kind = CMD_DESTROY;
            OP_LOCK:    o_cmd.kind = CMD_LOCK;
            OP_TRYLOCK: o_cmd.kind = CMD_TRYLOCK;
            OP_UNLOCK:  o_cmd.kind = CMD_UNLOCK;
            default:    o_cmd.kind = CMD_NOP;
        endcase
    end

endmodule

[design/mtfw_cmd_queue.sv]
// ----------------------------------------------------------------------------
// mtfw_cmd_queue
// Short command queue between the classifier and the execution stage.
// ----------------------------------------------------------------------------
module mtfw_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mtfw_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_not_empty,
    output mtfw_pkg::t_cmd o_cmd
);
    import mtfw_pkg::*;

    t_cmd               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QPTR_W:0]    r_count, n_count;

    assign o_full      = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_cmd       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[design/mtfw_back.sv]
// ----------------------------------------------------------------------------
// mtfw_back
// Execution stage: holds the slot table and waiter links, runs one command
// per cycle while its output register is empty or being read, and keeps the result in that output register.
// ----------------------------------------------------------------------------
module mtfw_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  mtfw_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output mtfw_pkg::t_rsp o_out_rsp
);
    import mtfw_pkg::*;

    logic [LOCK_SLOTS-1:0] r_slot_valid, r_slot_held, r_slot_wait;
    t_thread               r_head [LOCK_SLOTS];
    t_thread               r_tail [LOCK_SLOTS];
    t_thread               r_next [THREAD_COUNT];

    logic    r_out_valid;
    t_rsp    r_rsp, n_rsp;

    logic    cur_valid, cur_held, cur_wait;
    t_thread cur_head, cur_tail, head_next;
    logic    n_valid_bit, n_held_bit, n_wait_bit;
    logic    head_we, tail_we, next_we;
    t_thread head_wdata;

    assign o_cmd_pop   = i_cmd_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_rsp;

    assign cur_valid = r_slot_valid[i_cmd.slot];
    assign cur_held  = r_slot_held[i_cmd.slot];
    assign cur_wait  = r_slot_wait[i_cmd.slot];
    assign cur_head  = r_head[i_cmd.slot];
    assign cur_tail  = r_tail[i_cmd.slot];
    assign head_next = r_next[cur_head];

    always_comb begin
        logic eff_held, eff_wait;
        eff_held = cur_valid && cur_held;
        eff_wait = cur_valid && cur_wait;

        n_valid_bit = cur_valid;
        n_held_bit  = cur_held;
        n_wait_bit  = cur_wait;
        head_we     = 1'b0;
        tail_we     = 1'b0;
        next_we     = 1'b0;
        head_wdata  = i_cmd.thread;

        n_rsp.outcome          = OC_DONE;
        n_rsp.implicit_created = 1'b0;
        n_rsp.woken_valid      = 1'b0;
        n_rsp.woken_thread     = '0;

        unique case (i_cmd.kind) inside
            CMD_INIT: begin
                if (eff_wait) begin
                    n_rsp.outcome = OC_REFUSED;
                end else begin
                    n_valid_bit = 1'b1;
                    n_held_bit  = 1'b0;
                    n_wait_bit  = 1'b0;
                end
            end
            CMD_DESTROY: begin
                if (!cur_valid) begin
                    n_rsp.outcome = OC_ABSENT;
                end else if (cur_wait) begin
                    n_rsp.outcome = OC_REFUSED;
                end else begin
                    n_valid_bit = 1'b0;
                    n_held_bit  = 1'b0;
                end
            end
            CMD_LOCK, CMD_TRYLOCK, CMD_UNLOCK: begin
                // an absent slot is created free with an empty queue first
                n_rsp.implicit_created = !cur_valid;
                n_valid_bit = 1'b1;
                n_held_bit  = eff_held;
                n_wait_bit  = eff_wait;
                if (i_cmd.kind == CMD_UNLOCK) begin
                    if (eff_wait) begin
                        n_held_bit         = 1'b1;
                        n_rsp.outcome      = OC_HANDOFF;
                        n_rsp.woken_valid  = 1'b1;
                        n_rsp.woken_thread = 4'(cur_head);
                        if (cur_head == cur_tail) begin
                            n_wait_bit = 1'b0;
                        end else begin
                            head_we    = 1'b1;
                            head_wdata = head_next;
                        end
                    end else if (eff_held) begin
                        n_held_bit    = 1'b0;
                        n_rsp.outcome = OC_RELEASED;
                    end else begin
                        n_rsp.outcome = OC_ALREADY_FREE;
                    end
                end else if (!eff_held) begin
                    n_held_bit    = 1'b1;
                    n_rsp.outcome = OC_ACQUIRED;
                end else if (i_cmd.kind == CMD_TRYLOCK) begin
                    n_rsp.outcome = OC_BUSY;
                end else begin
                    // append at the tail; an empty queue gets a new head
                    if (eff_wait) begin
                        next_we = 1'b1;
                    end else begin
                        head_we    = 1'b1;
                        n_wait_bit = 1'b1;
                    end
                    tail_we       = 1'b1;
                    n_rsp.outcome = OC_QUEUED;
                end
            end
            default: begin
                n_rsp.outcome = OC_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            r_slot_held  <= '0;
            r_slot_wait  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_cmd_pop) begin
                r_slot_valid[i_cmd.slot] <= n_valid_bit;
                r_slot_held[i_cmd.slot]  <= n_held_bit;
                r_slot_wait[i_cmd.slot]  <= n_wait_bit;
                r_out_valid              <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_rsp <= n_rsp;
            if (head_we) begin
                r_head[i_cmd.slot] <= head_wdata;
            end
            if (tail_we) begin
                r_tail[i_cmd.slot] <= i_cmd.thread;
            end
            if (next_we) begin
                r_next[cur_tail] <= i_cmd.thread;
            end
        end
    end

endmodule

[design/mutex_table_fifo_waiters_top.sv]
// ----------------------------------------------------------------------------
// mutex_table_fifo_waiters_top
// Mutex table with a per-slot FIFO of waiting threads.
// ----------------------------------------------------------------------------
// Requests (op, lock_id, thread_id) enter on the i_in_valid / o_in_ready
// channel; each request gives exactly one response on o_out_valid /
// i_out_ready, in request order.
// A request is classified on entry and written to a two-entry command queue.
// The execution stage takes one command per cycle from that queue while the
// output register is empty or being read, updates the slot table and link
// store and loads the result into an output register. A request passes the
// queue and then the output register before o_out_valid rises. Throughput
// is one request per cycle while the receiver keeps up; the execution stage
// reads one slot entry and one link entry per command.
// When the receiver stalls, the output register holds its result and the
// execution stage stops; the queue then fills and o_in_ready drops after
// two more requests.
// Reset clears the slot valid, held and waiter flags, the queue and the
// output register; the head, tail and link stores need no clearing since
// they are only read behind a set waiter flag. No clearing pass is run.
// ----------------------------------------------------------------------------
module mutex_table_fifo_waiters_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  mtfw_pkg::t_req i_in_req,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output mtfw_pkg::t_rsp o_out_rsp
);
    import mtfw_pkg::*;

    t_cmd front_cmd, queue_cmd;
    logic queue_full, queue_not_empty, cmd_pop, push;

    assign o_in_ready = !queue_full;
    assign push       = i_in_valid && !queue_full;

    mtfw_front u_front (
        .i_req (i_in_req),
        .o_cmd (front_cmd)
    );

    mtfw_cmd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_cmd       (front_cmd),
        .o_full      (queue_full),
        .i_pop       (cmd_pop),
        .o_not_empty (queue_not_empty),
        .o_cmd       (queue_cmd)
    );

    mtfw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_not_empty),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

endmodule

[sim/mutex_table_fifo_waiters_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mutex_table_fifo_waiters_top_tb
// Self-checking bench for the mutex table with FIFO waiter queues.
// ----------------------------------------------------------------------------
// A short table of directed requests covers the operation codes, absent and
// refused slots, queue build-up and hand-off. Random requests follow, biased
// to a few busy slots in lock-heavy and unlock-heavy phases so that waiter
// queues grow and drain. Every response is checked in order, against the
// typed result of a directed row or else a local model of the slot table and
// link store. Both channels idle at random; once the receiver holds off long
// enough to back-pressure the input, and once the sender awaits every response.
// ----------------------------------------------------------------------------
module mutex_table_fifo_waiters_top_tb;
    import mtfw_pkg::*;

    localparam int          CLK_HALF         = 5;
    localparam int          RESET_CYCLES     = 7;
    localparam int          RAND_ITEMS       = 500;
    localparam int          LONG_HOLD_CYCLES = 100;
    localparam int          WATCHDOG_LIMIT   = 2000;
    localparam int          DRAIN_CYCLES     = 8;
    localparam int          HOLD_ITEM        = 120;
    localparam int          PAUSE_ITEM       = 300;
    localparam logic [2:0]  OP_RSVD5         = 3'd5;
    localparam logic [2:0]  OP_RSVD6         = 3'd6;
    localparam logic [2:0]  OP_RSVD7         = 3'd7;

    typedef struct {
        t_req req;
        bit   fixed;
        t_rsp rsp;
    } t_stim_row;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_ready;
    t_req i_in_req    = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_rsp o_out_rsp;

    // local copy of the slot table and link store
    bit      mx_valid   [LOCK_SLOTS];
    bit      mx_held    [LOCK_SLOTS];
    bit      mx_waiting [LOCK_SLOTS];
    t_thread q_head     [LOCK_SLOTS];
    t_thread q_tail     [LOCK_SLOTS];
    t_thread next_link  [THREAD_COUNT];

    t_rsp      pending_rsps [$];
    t_stim_row directed_rows [$];
    int        mismatch_count = 0;
    int        quiet_cycles   = 0;
    bit        hold_off_req   = 1'b0;
    bit        sender_steady  = 1'b0;

    mutex_table_fifo_waiters_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic t_rsp predict_mutex_rsp(input t_req req);
        t_rsp    rsp;
        t_slot   s;
        t_thread t;
        t_thread h;
        s = t_slot'(req.lock_id % LOCK_SLOTS);
        t = t_thread'(req.thread_id % THREAD_COUNT);
        rsp.outcome          = OC_DONE;
        rsp.implicit_created = 1'b0;
        rsp.woken_valid      = 1'b0;
        rsp.woken_thread     = '0;
        if ((req.op == OP_LOCK || req.op == OP_TRYLOCK || req.op == OP_UNLOCK)
                && !mx_valid[s]) begin
            mx_valid[s]          = 1'b1;
            mx_held[s]           = 1'b0;
            mx_waiting[s]        = 1'b0;
            rsp.implicit_created = 1'b1;
        end
        case (req.op)
            OP_INIT: begin
                if (mx_valid[s] && mx_waiting[s]) begin
                    rsp.outcome = OC_REFUSED;
                end else begin
                    mx_valid[s]   = 1'b1;
                    mx_held[s]    = 1'b0;
                    mx_waiting[s] = 1'b0;
                end
            end
            OP_DESTROY: begin
                if (!mx_valid[s]) begin
                    rsp.outcome = OC_ABSENT;
                end else if (mx_waiting[s]) begin
                    rsp.outcome = OC_REFUSED;
                end else begin
                    mx_valid[s] = 1'b0;
                    mx_held[s]  = 1'b0;
                end
            end
            OP_LOCK: begin
                if (!mx_held[s]) begin
                    mx_held[s]  = 1'b1;
                    rsp.outcome = OC_ACQUIRED;
                end else begin
                    // a thread already queued is simply appended again
                    if (mx_waiting[s]) begin
                        next_link[q_tail[s]] = t;
                    end else begin
                        q_head[s]     = t;
                        mx_waiting[s] = 1'b1;
                    end
                    q_tail[s]   = t;
                    rsp.outcome = OC_QUEUED;
                end
            end
            OP_TRYLOCK: begin
                if (!mx_held[s]) begin
                    mx_held[s]  = 1'b1;
                    rsp.outcome = OC_ACQUIRED;
                end else begin
                    rsp.outcome = OC_BUSY;
                end
            end
            OP_UNLOCK: begin
                if (mx_waiting[s]) begin
                    h                = q_head[s];
                    mx_held[s]       = 1'b1;
                    rsp.woken_valid  = 1'b1;
                    rsp.woken_thread = h;
                    if (h == q_tail[s]) begin
                        mx_waiting[s] = 1'b0;
                    end else begin
                        q_head[s] = next_link[h];
                    end
                    rsp.outcome = OC_HANDOFF;
                end else if (mx_held[s]) begin
                    mx_held[s]  = 1'b0;
                    rsp.outcome = OC_RELEASED;
                end else begin
                    rsp.outcome = OC_ALREADY_FREE;
                end
            end
            default: rsp.outcome = OC_DONE;
        endcase
        return rsp;
    endfunction

    function automatic void add_req(input logic [2:0] op, input logic [3:0] lock_id,
                                    input logic [3:0] thread_id);
        t_stim_row row;
        row.req.op        = op;
        row.req.lock_id   = lock_id;
        row.req.thread_id = thread_id;
        row.fixed         = 1'b0;
        row.rsp           = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_typed(input logic [2:0] op, input logic [3:0] lock_id,
                                      input logic [3:0] thread_id, input t_outcome oc,
                                      input logic created, input logic woken,
                                      input logic [3:0] woken_thread);
        t_stim_row row;
        row.req.op               = op;
        row.req.lock_id          = lock_id;
        row.req.thread_id        = thread_id;
        row.fixed                = 1'b1;
        row.rsp.outcome          = oc;
        row.rsp.implicit_created = created;
        row.rsp.woken_valid      = woken;
        row.rsp.woken_thread     = woken_thread;
        directed_rows.push_back(row);
    endfunction

    function automatic int sender_gap();
        int r;
        if (sender_steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // offer one request and hold it until accepted; the model steps on acceptance
    task automatic offer_req(input t_req req, input bit fixed, input t_rsp fixed_rsp);
        t_rsp model_rsp;
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        model_rsp = predict_mutex_rsp(req);
        pending_rsps.push_back(fixed ? fixed_rsp : model_rsp);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            i_in_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    function automatic t_req random_req(input bit lock_heavy);
        t_req req;
        int   r;
        r = $urandom_range(0, 99);
        if (r < (lock_heavy ? 45 : 15)) begin
            req.op = OP_LOCK;
        end else if (r < 70) begin
            req.op = OP_UNLOCK;
        end else if (r < 80) begin
            req.op = OP_TRYLOCK;
        end else if (r < 86) begin
            req.op = OP_INIT;
        end else if (r < 92) begin
            req.op = OP_DESTROY;
        end else begin
            case ($urandom_range(0, 2))
                0:       req.op = OP_RSVD5;
                1:       req.op = OP_RSVD6;
                default: req.op = OP_RSVD7;
            endcase
        end
        // mostly a few busy slots so that queues form
        if ($urandom_range(0, 3) != 0) begin
            req.lock_id = 4'($urandom_range(0, 3));
        end else begin
            req.lock_id = 4'($urandom_range(0, 15));
        end
        req.thread_id = 4'($urandom_range(0, 15));
        return req;
    endfunction

    // receiver: random stalls, ready runs, and one long hold-off on request
    initial begin
        forever begin
            int r;
            r = $urandom_range(0, 99);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
            end else if (r < 50) begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else if (r < 92) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : rsp_check
        t_rsp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_rsps.size() == 0) begin
                $error("response with no request outstanding: outcome %0d", o_out_rsp.outcome);
                mismatch_count++;
            end else begin
                want = pending_rsps.pop_front();
                if (o_out_rsp.outcome !== want.outcome) begin
                    $error("outcome: expected %0d, got %0d", want.outcome, o_out_rsp.outcome);
                    mismatch_count++;
                end
                if (o_out_rsp.implicit_created !== want.implicit_created) begin
                    $error("implicit_created: expected %0d, got %0d",
                           want.implicit_created, o_out_rsp.implicit_created);
                    mismatch_count++;
                end
                if (o_out_rsp.woken_valid !== want.woken_valid) begin
                    $error("woken_valid: expected %0d, got %0d",
                           want.woken_valid, o_out_rsp.woken_valid);
                    mismatch_count++;
                end
                if (o_out_rsp.woken_thread !== want.woken_thread) begin
                    $error("woken_thread: expected %0d, got %0d",
                           want.woken_thread, o_out_rsp.woken_thread);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        t_req req;
        t_rsp none;
        none = '0;

        for (int i = 0; i < LOCK_SLOTS; i++) begin
            mx_valid[i]   = 1'b0;
            mx_held[i]    = 1'b0;
            mx_waiting[i] = 1'b0;
            q_head[i]     = '0;
            q_tail[i]     = '0;
        end
        for (int i = 0; i < THREAD_COUNT; i++) next_link[i] = '0;

        add_typed(OP_DESTROY, 4'd0,  4'd0,  OC_ABSENT,       1'b0, 1'b0, 4'd0);
        add_typed(OP_UNLOCK,  4'd15, 4'd15, OC_ALREADY_FREE, 1'b1, 1'b0, 4'd0);
        add_typed(OP_TRYLOCK, 4'd3,  4'd1,  OC_ACQUIRED,     1'b1, 1'b0, 4'd0);
        add_typed(OP_TRYLOCK, 4'd3,  4'd2,  OC_BUSY,         1'b0, 1'b0, 4'd0);
        add_req(OP_LOCK, 4'd3, 4'd4);
        add_req(OP_LOCK, 4'd3, 4'd15);
        add_req(OP_LOCK, 4'd3, 4'd4);       // same thread queued twice
        add_typed(OP_INIT,    4'd3,  4'd0,  OC_REFUSED,      1'b0, 1'b0, 4'd0);
        add_typed(OP_DESTROY, 4'd3,  4'd0,  OC_REFUSED,      1'b0, 1'b0, 4'd0);
        add_req(OP_UNLOCK, 4'd3, 4'd1);     // head is also the tail, queue empties
        add_req(OP_UNLOCK, 4'd3, 4'd4);
        add_req(OP_UNLOCK, 4'd3, 4'd15);
        add_req(OP_UNLOCK, 4'd3, 4'd4);
        add_req(OP_UNLOCK, 4'd3, 4'd4);
        add_typed(OP_DESTROY, 4'd3,  4'd0,  OC_DONE,         1'b0, 1'b0, 4'd0);
        add_typed(OP_INIT,    4'd0,  4'd15, OC_DONE,         1'b0, 1'b0, 4'd0);
        add_req(OP_INIT, 4'd0, 4'd0);
        add_req(OP_LOCK, 4'd0, 4'd0);
        add_req(OP_LOCK, 4'd0, 4'd0);
        add_req(OP_UNLOCK, 4'd0, 4'd15);
        add_typed(OP_RSVD5,   4'd15, 4'd15, OC_DONE,         1'b0, 1'b0, 4'd0);
        add_typed(OP_RSVD6,   4'd0,  4'd0,  OC_DONE,         1'b0, 1'b0, 4'd0);
        add_typed(OP_RSVD7,   4'd10, 4'd5,  OC_DONE,         1'b0, 1'b0, 4'd0);
        add_req(OP_LOCK, 4'd15, 4'd15);
        add_req(OP_TRYLOCK, 4'd10, 4'd10);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            offer_req(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].rsp);
            idle_sender(sender_gap());
        end

        for (int n = 0; n < RAND_ITEMS; n++) begin
            // back-to-back stretch around the receiver hold-off fills the block
            sender_steady = (n >= HOLD_ITEM - 5 && n < HOLD_ITEM + 50) || ((n / 40) % 5 == 3);
            if (n == HOLD_ITEM) hold_off_req = 1'b1;
            if (n == PAUSE_ITEM) begin
                i_in_valid <= 1'b0;
                while (pending_rsps.size() != 0) @(posedge i_clk);
                @(posedge i_clk);
            end
            req = random_req(((n / 60) % 2) == 0);
            offer_req(req, 1'b0, none);
            idle_sender(sender_gap());
        end
        i_in_valid <= 1'b0;

        while (pending_rsps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[sim.f]
design/mtfw_pkg.sv
design/mtfw_front.sv
design/mtfw_cmd_queue.sv
design/mtfw_back.sv
design/mutex_table_fifo_waiters_top.sv
sim/mutex_table_fifo_waiters_top_tb.sv
